/* src/pmlh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pmlh_pkg;

  localparam int KEY_DEPTH_DEFAULT = 1024;
  localparam int VALUE_W = 32;
  localparam int RUN_W = 16;
  localparam int HASH_W = 64;
  localparam int CMD_W = 2;

  localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'h1465_0FB0_739D_0383;
  localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
  // prime is 2^40 + 0x1b3: a shift plus a narrow multiply
  localparam int FNV_PRIME_SHIFT = 40;
  localparam logic [8:0] FNV_PRIME_LO = FNV_PRIME[8:0];

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_LOOKUP,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t op;
    logic [VALUE_W-1:0] value;
    logic last;
  } item_t;

endpackage
`default_nettype wire

/* src/pmlh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmlh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/pmlh_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmlh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CNT_FULL);
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/pmlh_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmlh_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [pmlh_pkg::CMD_W-1:0]      cmd,
  input  wire logic [pmlh_pkg::VALUE_W-1:0]    value,
  input  wire logic                            last_block,
  output logic                                 q_valid,
  output pmlh_pkg::item_t                      q_item,
  input  wire logic                            q_pop
);
  import pmlh_pkg::*;

  localparam int ITEM_W = $bits(item_t);

  item_t in_item;
  logic [ITEM_W-1:0] fifo_dout;
  logic fifo_empty;

  // decode command; last only means something on a lookup
  always_comb begin
    in_item.value = value;
    in_item.last = 1'b0;
    case (cmd)
      CMD_CLEAR: in_item.op = OP_CLEAR;
      CMD_LOAD: in_item.op = OP_LOAD;
      CMD_REQUEST: begin
        in_item.op = OP_LOOKUP;
        in_item.last = last_block;
      end
      CMD_EMPTY: in_item.op = OP_EMPTY;
      default: in_item.op = OP_EMPTY;
    endcase
  end

  pmlh_fifo #(
    .WIDTH(ITEM_W),
    .DEPTH(2)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (in_item),
    .full (full),
    .pop  (q_pop),
    .dout (fifo_dout),
    .empty(fifo_empty)
  );

  assign q_valid = !fifo_empty;
  assign q_item = item_t'(fifo_dout);

endmodule
`default_nettype wire

/* src/pmlh_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module pmlh_back #(
  parameter int KEY_DEPTH = pmlh_pkg::KEY_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire pmlh_pkg::item_t               q_item,
  output logic                               q_pop,
  output logic                               res_push,
  input  wire logic                          res_full,
  output logic [pmlh_pkg::RUN_W-1:0]         res_length,
  output logic [pmlh_pkg::HASH_W-1:0]        res_hash
);
  import pmlh_pkg::*;

  localparam int ADDR_W = $clog2(KEY_DEPTH);
  localparam int CNT_W = $clog2(KEY_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(KEY_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_XOR,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  state_t state;
  logic [CNT_W-1:0] key_count;
  logic [CNT_W-1:0] scan_addr;
  logic data_ok;
  logic [VALUE_W-1:0] look_value;
  logic look_last;
  logic [RUN_W-1:0] run_length;
  logic still_matching;
  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] mix_x;
  logic [HASH_W-1:0] mix_prod;

  logic ram_we;
  logic ram_re;
  logic issue_valid;
  logic [VALUE_W-1:0] ram_rdata;
  logic [RUN_W-1:0] run_inc;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign ram_we = q_pop && (q_item.op == OP_LOAD) && (key_count < DEPTH_CNT);
  assign issue_valid = (scan_addr < key_count);
  assign ram_re = (state == S_SCAN) && issue_valid;
  assign run_inc = (run_length == RUN_MAX) ? run_length : run_length + 1'b1;

  assign res_push = (state == S_EMIT) && !res_full;
  assign res_length = run_length;
  assign res_hash = running_hash;

  pmlh_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(KEY_DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(key_count[ADDR_W-1:0]),
    .wdata(q_item.value),
    .re   (ram_re),
    .raddr(scan_addr[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      key_count <= '0;
      run_length <= '0;
      still_matching <= 1'b1;
      running_hash <= FNV_BASIS;
      scan_addr <= '0;
      data_ok <= 1'b0;
      look_last <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_CLEAR: begin
                key_count <= '0;
                run_length <= '0;
                still_matching <= 1'b1;
                running_hash <= FNV_BASIS;
              end
              OP_LOAD: begin
                if (key_count < DEPTH_CNT) begin
                  key_count <= key_count + 1'b1;
                end
              end
              OP_LOOKUP: begin
                look_value <= q_item.value;
                look_last <= q_item.last;
                scan_addr <= '0;
                data_ok <= 1'b0;
                if (still_matching && key_count != '0) begin
                  state <= S_SCAN;
                end else begin
                  // empty table is a miss
                  still_matching <= 1'b0;
                  state <= q_item.last ? S_XOR : S_IDLE;
                end
              end
              OP_EMPTY: begin
                run_length <= '0;
                state <= S_XOR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (data_ok && ram_rdata == look_value) begin
            run_length <= run_inc;
            state <= look_last ? S_XOR : S_IDLE;
          end else if (!data_ok && !issue_valid) begin
            still_matching <= 1'b0;
            state <= look_last ? S_XOR : S_IDLE;
          end else begin
            data_ok <= issue_valid;
            if (issue_valid) begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
        end
        S_XOR: begin
          mix_x <= running_hash ^ HASH_W'(run_length);
          state <= S_MUL;
        end
        S_MUL: begin
          mix_prod <= mix_x * HASH_W'(FNV_PRIME_LO);
          state <= S_ADD;
        end
        S_ADD: begin
          running_hash <= (mix_x << FNV_PRIME_SHIFT) + mix_prod;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_full) begin
            run_length <= '0;
            still_matching <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_restores: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.op == OP_CLEAR) |=>
      (key_count == '0 && running_hash == FNV_BASIS && still_matching))
    else $error("clear did not restore table and hash");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= DEPTH_CNT)
    else $error("key count beyond table depth");

  a_push_restarts: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (state == S_IDLE && run_length == '0 && still_matching))
    else $error("run not restarted after result");

  a_no_scan_after_miss: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> still_matching)
    else $error("lookup scan while request already missed");

endmodule
`default_nettype wire

/* src/prefix_match_length_hasher_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake          payload
// command   in         push / full        cmd, value, last_block
// result    out        pop / empty        prefix_length, checksum
//
// clear, load and non-scanning lookups are handled in the back end without a scan
// a lookup while the request still matches scans the key memory linearly,
//   one read a cycle, stopping early on a hit;
//   the single read port of the key memory sets this rate
// ending a request steps through xor, multiply, add and hand-off to the result queue
// rst is synchronous: table count, run state and hash return to their reset values;
//   key memory contents are not cleared, a fill count guards them
// a two-beat command queue and a two-beat result queue let either side stall alone
module prefix_match_length_hasher_core #(
  parameter int KEY_DEPTH = pmlh_pkg::KEY_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command side
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [pmlh_pkg::CMD_W-1:0]    cmd,
  input  wire logic [pmlh_pkg::VALUE_W-1:0]  value,
  input  wire logic                          last_block,
  // result side
  input  wire logic                          pop,
  output logic                               empty,
  output logic [pmlh_pkg::RUN_W-1:0]         prefix_length,
  output logic [pmlh_pkg::HASH_W-1:0]        checksum
);
  import pmlh_pkg::*;

  localparam int RES_W = RUN_W + HASH_W;

  // front to back: decoded command beats
  logic q_valid;
  item_t q_item;
  logic q_pop;

  // back to result queue
  logic res_push;
  logic res_full;
  logic [RUN_W-1:0] res_length;
  logic [HASH_W-1:0] res_hash;
  logic [RES_W-1:0] res_dout;

  // accepts and decodes commands into a short queue
  pmlh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .value     (value),
    .last_block(last_block),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // owns the key memory, the run counter and the running hash
  pmlh_back #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_push  (res_push),
    .res_full  (res_full),
    .res_length(res_length),
    .res_hash  (res_hash)
  );

  // result queue: oldest result sits on the ports while not empty
  pmlh_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  ({res_length, res_hash}),
    .full (res_full),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign prefix_length = res_dout[RES_W-1:HASH_W];
  assign checksum = res_dout[HASH_W-1:0];

endmodule
`default_nettype wire

/* bench/prefix_match_length_hasher_core_test.sv */
`timescale 1ns / 1ps
module prefix_match_length_hasher_core_test;
  import pmlh_pkg::*;

  localparam int KEY_DEPTH = KEY_DEPTH_DEFAULT;
  localparam int RANDOM_BEATS = 880;
  // long receiver hold-off, enough to back the block up into its command queue
  localparam int HOLD_CYCLES = 400;
  // leave plenty of room above the length of a full-table scan
  localparam int QUIET_LIMIT = 4 * KEY_DEPTH + 2000;
  // random traffic keeps the table small so that scans stay short
  localparam int TABLE_CAP = 48;
  // keep the log short on a badly broken design
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [RUN_W-1:0]  length;
    logic [HASH_W-1:0] sum;
  } digest_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [CMD_W-1:0]   cmd = CMD_CLEAR;
  logic [VALUE_W-1:0] value = '0;
  logic               last_block = 1'b0;
  logic               pop = 1'b0;
  logic               empty;
  logic [RUN_W-1:0]   prefix_length;
  logic [HASH_W-1:0]  checksum;

  // mirror of the block state, advanced on every accepted command beat
  logic [VALUE_W-1:0] key_mirror [KEY_DEPTH];
  int unsigned        keys_loaded;
  logic [RUN_W-1:0]   match_run;
  bit                 run_alive;
  logic [HASH_W-1:0]  hash_mirror;
  // digests still owed by the block, oldest first
  digest_t            digest_queue [$];

  int error_count = 0;
  int beats_sent = 0;
  int burst_left = 0;
  // when set the sender offers beats back to back with no gaps
  bit steady_sender = 1'b0;
  // each toggle asks the receiver for one long hold-off
  bit hold_req = 1'b0;

  prefix_match_length_hasher_core #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .cmd(cmd),
    .value(value),
    .last_block(last_block),
    .pop(pop),
    .empty(empty),
    .prefix_length(prefix_length),
    .checksum(checksum)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // advance the mirror by one command beat; a finished request queues its digest
  function automatic void mirror_beat(input logic [CMD_W-1:0] c,
                                      input logic [VALUE_W-1:0] v,
                                      input logic l);
    bit hit;
    case (c)
      CMD_CLEAR: begin
        keys_loaded = 0;
        match_run = '0;
        run_alive = 1'b1;
        hash_mirror = FNV_BASIS;
      end
      CMD_LOAD: begin
        // loads into a full table are dropped
        if (keys_loaded < KEY_DEPTH) begin
          key_mirror[keys_loaded] = v;
          keys_loaded++;
        end
      end
      CMD_REQUEST: begin
        // once a block misses, the rest of the request is not looked up
        if (run_alive) begin
          hit = 1'b0;
          for (int i = 0; i < keys_loaded; i++) begin
            if (key_mirror[i] == v) hit = 1'b1;
          end
          if (hit) begin
            if (match_run != RUN_MAX) match_run++;
          end else begin
            run_alive = 1'b0;
          end
        end
        if (l) begin
          hash_mirror = (hash_mirror ^ HASH_W'(match_run)) * FNV_PRIME;
          digest_queue.push_back('{match_run, hash_mirror});
          match_run = '0;
          run_alive = 1'b1;
        end
      end
      CMD_EMPTY: begin
        // mixes a zero count and drops any partial request
        hash_mirror = hash_mirror * FNV_PRIME;
        digest_queue.push_back('{'0, hash_mirror});
        match_run = '0;
        run_alive = 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] want);
    if (error_count < REPORT_CAP)
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // offer one command beat and hold it until accepted; then maybe idle for a gap
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v,
                           input logic l);
    push <= 1'b1;
    cmd <= c;
    value <= v;
    last_block <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    mirror_beat(c, v, l);
    beats_sent++;
    if (!steady_sender) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // a real gap so push never drops and rises in one step
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(0, 6);
      end
    end
  endtask

  // stop offering beats until every owed digest has come back
  task automatic pause_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  // receiver: runs of pops and short stalls, plus a long hold-off on request
  int  recv_left = 0;
  int  hold_left = 0;
  bit  hold_seen = 1'b0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (recv_left > 0) begin
      recv_left <= recv_left - 1;
    end else if (pop) begin
      pop <= 1'b0;
      recv_left <= $urandom_range(0, 5);
    end else begin
      pop <= 1'b1;
      recv_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(0, 10);
    end
  end

  // every accepted result beat must match the oldest owed digest
  always @(posedge clk) begin : check_results
    digest_t want;
    if (!rst && pop && !empty) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("result beat with nothing expected", checksum, 'x);
      end else begin
        want = digest_queue.pop_front();
        if (prefix_length !== want.length)
          report_mismatch("prefix_length", HASH_W'(prefix_length), HASH_W'(want.length));
        if (checksum !== want.sum)
          report_mismatch("checksum", checksum, want.sum);
      end
    end
  end

  // edge values, each command, miss handling and dropped partial requests
  task automatic test_directed_cases();
    // empty request and a lookup before any key exists; last_block ignored on empty
    send_beat(CMD_EMPTY, 32'hFFFF_FFFF, 1'b1);
    send_beat(CMD_REQUEST, 32'h0000_0000, 1'b1);
    // loads with last_block set and clear, plus a duplicate key
    send_beat(CMD_LOAD, 32'h0000_0000, 1'b1);
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, 32'h8000_0005, 1'b0);
    send_beat(CMD_LOAD, 32'h8000_0005, 1'b1);
    // every block hits, out of load order
    send_beat(CMD_REQUEST, 32'h8000_0005, 1'b0);
    send_beat(CMD_REQUEST, 32'h0000_0000, 1'b0);
    send_beat(CMD_REQUEST, 32'hFFFF_FFFF, 1'b1);
    // miss in the middle: the hit after it does not count
    send_beat(CMD_REQUEST, 32'h8000_0005, 1'b0);
    send_beat(CMD_REQUEST, 32'h0000_0007, 1'b0);
    send_beat(CMD_REQUEST, 32'h0000_0000, 1'b1);
    // single block that misses
    send_beat(CMD_REQUEST, 32'h7FFF_FFFF, 1'b1);
    // partial request dropped by an empty request
    send_beat(CMD_REQUEST, 32'h0000_0000, 1'b0);
    send_beat(CMD_EMPTY, 32'h0000_0000, 1'b0);
    // partial request dropped by clear; the table is gone afterwards
    send_beat(CMD_REQUEST, 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_beat(CMD_REQUEST, 32'hFFFF_FFFF, 1'b1);
    pause_until_drained();
  endtask

  // receiver holds off while the sender keeps pushing result-making beats
  task automatic test_backpressure();
    steady_sender = 1'b1;
    hold_req <= ~hold_req;
    for (int i = 0; i < 40; i++)
      send_beat(CMD_EMPTY, $urandom, 1'($urandom_range(0, 1)));
    steady_sender = 1'b0;
    pause_until_drained();
  endtask

  // mostly small tables and well-formed requests, with noise and broken runs
  task automatic test_random_traffic();
    int stop_at;
    int len;
    int pick;
    bit drained;
    logic [VALUE_W-1:0] v;
    stop_at = beats_sent + RANDOM_BEATS;
    drained = 1'b0;
    while (beats_sent < stop_at) begin
      // one full pause part way through
      if (!drained && beats_sent > stop_at - RANDOM_BEATS / 2) begin
        pause_until_drained();
        drained = 1'b1;
      end
      if (keys_loaded >= TABLE_CAP)
        send_beat(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_beat(CMD_CLEAR, $urandom, 1'($urandom_range(0, 1)));
      end else if (pick < 20) begin
        // load burst: random keys, small keys and duplicates
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) begin
          if (keys_loaded > 0 && $urandom_range(0, 3) == 0)
            v = key_mirror[$urandom_range(0, keys_loaded - 1)];
          else if ($urandom_range(0, 3) == 0)
            v = $urandom_range(0, 15);
          else
            v = $urandom;
          send_beat(CMD_LOAD, v, 1'($urandom_range(0, 1)));
        end
      end else if (pick < 85) begin
        // request: mostly table keys so runs get long before the first miss
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          if (keys_loaded > 0 && $urandom_range(0, 4) != 0)
            v = key_mirror[$urandom_range(0, keys_loaded - 1)];
          else
            v = $urandom;
          // now and then the request is broken off
          if ($urandom_range(0, 39) == 0)
            send_beat($urandom_range(0, 1) ? CMD_EMPTY : CMD_CLEAR, $urandom, 1'b1);
          send_beat(CMD_REQUEST, v, j == len - 1);
        end
      end else if (pick < 92) begin
        send_beat(CMD_EMPTY, $urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_beat(CMD_W'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ends the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    // reset state of the block equals a clear
    mirror_beat(CMD_CLEAR, '0, 1'b0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_backpressure();
    test_random_traffic();
    pause_until_drained();
    // room for a stray result from a scan still running
    repeat (KEY_DEPTH + 32) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
